// ===== src/ptu_pkg.sv =====
// Package with the transaction types, opcodes and descriptor constants of the page-table unit.
package ptu_pkg;

    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned ENTRY_W = 64;
    localparam int unsigned PFN_W   = 36;
    localparam int unsigned OFFS_W  = 12;
    localparam int unsigned IDX_W   = 9;

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_UNMAP = 2'd1;
    localparam logic [1:0] OP_XLATE = 2'd2;

    localparam int unsigned D_VALID    = 0;
    localparam int unsigned D_TABLE    = 1;
    localparam int unsigned D_ATTR_DEV = 2;
    localparam int unsigned D_AP_USER  = 6;
    localparam int unsigned D_AP_RO    = 7;
    localparam int unsigned D_SH_LO    = 8;
    localparam int unsigned D_SH_HI    = 9;
    localparam int unsigned D_AF       = 10;
    localparam int unsigned D_PXN      = 53;
    localparam int unsigned D_UXN      = 54;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] phys_in;
        logic              flag_write;
        logic              flag_exec;
        logic              flag_user;
        logic              flag_device;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [ENTRY_W-1:0] leaf_word;
        logic [ADDR_W-1:0]  phys_out;
    } out_item_t;

endpackage

// ===== src/ptu_mem.sv =====
// Single-port table store with a registered read port.
module ptu_mem #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = 13
) (
    input  logic                        aclk,
    input  logic [AW-1:0]               addr,
    input  logic                        we,
    input  logic [ptu_pkg::ENTRY_W-1:0] wdata,
    output logic [ptu_pkg::ENTRY_W-1:0] rdata
);
    import ptu_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ptu_ctrl.sv =====
// Walk sequencer: clears the store after reset, then walks, allocates and updates entries.
module ptu_ctrl #(
    parameter int unsigned TABLE_FRAMES = 16,
    parameter int unsigned AW           = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ptu_pkg::in_item_t           s_data,
    input  logic [ptu_pkg::PFN_W-1:0]   base_pfn,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ptu_pkg::out_item_t          res_data,
    output logic [AW-1:0]               mem_addr,
    output logic                        mem_we,
    output logic [ptu_pkg::ENTRY_W-1:0] mem_wdata,
    input  logic [ptu_pkg::ENTRY_W-1:0] mem_rdata
);
    import ptu_pkg::*;

    localparam int unsigned FW    = AW - IDX_W;
    localparam int unsigned NW    = $clog2(TABLE_FRAMES + 1);
    localparam int unsigned DEPTH = TABLE_FRAMES * (2 ** IDX_W);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_EV   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [1:0] LVL_LEAF = 2'd3;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    level_reg, level_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic [NW-1:0] nff_reg, nff_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    in_item_t      item_reg, item_next;
    out_item_t     res_reg, res_next;

    logic [IDX_W-1:0] idx;
    logic [PFN_W-1:0] diff;
    logic             ptr_ok;
    logic [PFN_W-1:0] new_pfn;
    logic [ENTRY_W-1:0] page_desc;

    function automatic logic [ENTRY_W-1:0] make_page(input in_item_t it);
        logic [ENTRY_W-1:0] d;
        d = {16'd0, it.phys_in[ADDR_W-1:OFFS_W], 12'd0};
        d[D_VALID] = 1'b1;
        d[D_TABLE] = 1'b1;
        d[D_AF]    = 1'b1;
        if (it.flag_device) begin
            d[D_ATTR_DEV] = 1'b1;
            d[D_UXN]      = 1'b1;
            d[D_PXN]      = 1'b1;
        end else begin
            d[D_SH_LO] = 1'b1;
            d[D_SH_HI] = 1'b1;
        end
        if (!it.flag_write) begin
            d[D_AP_RO] = 1'b1;
        end
        if (it.flag_user) begin
            d[D_AP_USER] = 1'b1;
        end
        if (!it.flag_exec) begin
            d[D_UXN] = 1'b1;
            d[D_PXN] = 1'b1;
        end else if (!it.flag_user) begin
            d[D_UXN] = 1'b1;
        end
        return d;
    endfunction

    always_comb begin
        case (level_reg)
            2'd0:    idx = item_reg.virt_addr[47:39];
            2'd1:    idx = item_reg.virt_addr[38:30];
            2'd2:    idx = item_reg.virt_addr[29:21];
            default: idx = item_reg.virt_addr[20:12];
        endcase
    end

    // A table pointer is followed only when it names a frame under the current base.
    assign diff      = mem_rdata[ADDR_W-1:OFFS_W] - base_pfn;
    assign ptr_ok    = mem_rdata[D_VALID] && mem_rdata[D_TABLE] &&
                       (diff < PFN_W'(TABLE_FRAMES));
    assign new_pfn   = base_pfn + PFN_W'(nff_reg);
    assign page_desc = make_page(item_reg);

    always_comb begin
        state_next    = state_reg;
        level_next    = level_reg;
        frame_next    = frame_reg;
        nff_next      = nff_reg;
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_wdata     = '0;
        mem_addr      = {frame_reg, idx};

        case (state_reg)
            ST_CLR: begin
                mem_addr = clr_addr_reg;
                mem_we   = 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    level_next = 2'd0;
                    frame_next = '0;
                    res_next   = '{status: 1'b1, leaf_word: '0, phys_out: '0};
                    state_next = ST_DONE;
                    case (s_data.op)
                        OP_MAP: begin
                            if (s_data.virt_addr[OFFS_W-1:0] == '0 &&
                                s_data.phys_in[OFFS_W-1:0] == '0) begin
                                state_next = ST_RD;
                            end
                        end
                        OP_UNMAP: begin
                            if (s_data.virt_addr[OFFS_W-1:0] == '0) begin
                                state_next = ST_RD;
                            end
                        end
                        OP_XLATE: begin
                            state_next = ST_RD;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                state_next = ST_DONE;
                res_next   = '{status: 1'b1, leaf_word: '0, phys_out: '0};
                if (level_reg != LVL_LEAF) begin
                    if (item_reg.op == OP_MAP && !mem_rdata[D_VALID]) begin
                        // Empty slot on the way down: take the next free frame.
                        if (nff_reg < NW'(TABLE_FRAMES)) begin
                            mem_we     = 1'b1;
                            mem_wdata  = {16'd0, new_pfn, 12'd0};
                            mem_wdata[D_VALID] = 1'b1;
                            mem_wdata[D_TABLE] = 1'b1;
                            frame_next = nff_reg[FW-1:0];
                            nff_next   = nff_reg + 1'b1;
                            level_next = level_reg + 1'b1;
                            state_next = ST_RD;
                        end
                    end else if (ptr_ok) begin
                        frame_next = diff[FW-1:0];
                        level_next = level_reg + 1'b1;
                        state_next = ST_RD;
                    end else if (item_reg.op == OP_XLATE) begin
                        res_next.status = 1'b0;
                    end
                end else begin
                    case (item_reg.op)
                        OP_MAP: begin
                            if (!mem_rdata[D_VALID]) begin
                                mem_we          = 1'b1;
                                mem_wdata       = page_desc;
                                res_next.status = 1'b0;
                            end
                        end
                        OP_UNMAP: begin
                            if (mem_rdata[D_VALID]) begin
                                mem_we          = 1'b1;
                                mem_wdata       = '0;
                                res_next.status = 1'b0;
                            end
                        end
                        default: begin
                            res_next.status    = 1'b0;
                            res_next.leaf_word = mem_rdata;
                            if (mem_rdata[D_VALID] && mem_rdata[D_TABLE]) begin
                                res_next.phys_out = {mem_rdata[ADDR_W-1:OFFS_W],
                                                     item_reg.virt_addr[OFFS_W-1:0]};
                            end
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            level_reg    <= 2'd0;
            frame_reg    <= '0;
            nff_reg      <= NW'(1);
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            frame_reg    <= frame_next;
            nff_reg      <= nff_next;
            clr_addr_reg <= clr_addr_next;
        end
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = res_reg;

`ifndef ASSERT_OFF
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_EV || state_reg == ST_CLR))
        else $error("store written outside the evaluate or clear states");
    a_nff_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nff_reg <= NW'(TABLE_FRAMES))
        else $error("free frame counter past the frame count");
    a_frame_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |-> (frame_reg < FW'(TABLE_FRAMES) || FW'(TABLE_FRAMES) == '0))
        else $error("walk frame out of range");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while one is in flight");
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("pending result changed before it was taken");
`endif

endmodule

// ===== src/page_table_map_unmap_translate_unit.sv =====
// Top level of the page-table unit: configuration register, output register, sequencer, store.
//
//  Channel  Ports                       Direction  Carries
//  cfg      cfg_valid/cfg_ready/cfg_data in        table_base (bits 11..0 ignored)
//  s        s_valid/s_ready/s_data       in        one map, unmap or translate request
//  m        m_valid/m_ready/m_data       out       status, leaf descriptor, physical address
//
//  After reset the store is cleared one entry a cycle, all TABLE_FRAMES*512 entries,
//  before s_ready rises.
//  A request reads one table level at a time, a read state then an evaluate state (up to
//  four levels), then waits in the done state to hand its result over and returns to idle
//  before the next request is taken; a rejected request skips the reads.
//  The single store port and the dependent level-by-level reads keep the walk serial.
//  The result sits in an output register, so the next request is taken while it waits.
module page_table_map_unmap_translate_unit #(
    parameter int unsigned TABLE_FRAMES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ptu_pkg::ADDR_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ptu_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ptu_pkg::out_item_t          m_data
);
    import ptu_pkg::*;

    localparam int unsigned DEPTH = TABLE_FRAMES * (2 ** IDX_W);
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [PFN_W-1:0] base_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic               res_valid;
    logic               res_ready;
    out_item_t          res_data;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data[ADDR_W-1:OFFS_W];
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ptu_ctrl #(
        .TABLE_FRAMES (TABLE_FRAMES),
        .AW           (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .base_pfn  (base_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_addr  (mem_addr),
        .mem_we    (mem_we),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    ptu_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the page-table map, unmap and translate unit.
module testbench;
    import ptu_pkg::*;

    localparam int unsigned N_FRAMES   = 16;
    localparam int unsigned ENTRIES    = 512;
    localparam int unsigned CYCLE_CAP  = 1_000_000;
    localparam int unsigned SETTLE     = 20;
    localparam logic [1:0]  OP_RSVD    = 2'd3;
    localparam logic [47:0] TOP_PAGE   = 48'hFFFF_FFFF_F000;
    localparam int unsigned POOL_N     = 7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ADDR_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    // Shadow copy of the table store, the frame allocator and the base register.
    logic [ENTRY_W-1:0] pt_mem [0:N_FRAMES*ENTRIES-1];
    int unsigned next_frame = 1;
    logic [ADDR_W-1:0] tbl_base = '0;

    in_item_t  page_reqs_q[$];
    out_item_t op_outcomes_q[$];
    int unsigned n_queued = 0;
    int unsigned n_done = 0;
    int unsigned err_cnt = 0;
    int unsigned tx_gap = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_calm = 0;
    int unsigned rx_wait;
    int unsigned cyc = 0;

    // Level 0..2 prefixes (va bits 47..21) under which the directed part maps pages.
    logic [26:0] leaf_pool [0:POOL_N-1];

    page_table_map_unmap_translate_unit #(
        .TABLE_FRAMES(N_FRAMES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [8:0] level_idx(logic [ADDR_W-1:0] va, int lvl);
        return 9'(va >> (39 - 9 * lvl));
    endfunction

    // Frame that a table descriptor points at under the current base, or -1.
    function automatic int table_frame(logic [ENTRY_W-1:0] e);
        logic [ADDR_W-1:0] rel_addr;
        if (!e[D_VALID] || !e[D_TABLE]) return -1;
        rel_addr = {e[47:12], 12'h000} - tbl_base;
        if (rel_addr[47:12] >= N_FRAMES) return -1;
        return int'(rel_addr[47:12]);
    endfunction

    function automatic int descend_map(int frame, logic [8:0] idx);
        int slot;
        logic [ENTRY_W-1:0] e;
        slot = frame * ENTRIES + int'(idx);
        if (pt_mem[slot][D_VALID]) return table_frame(pt_mem[slot]);
        if (next_frame >= N_FRAMES) return -1;
        e = '0;
        e[47:12] = tbl_base[47:12] + 36'(next_frame);
        e[D_VALID] = 1'b1;
        e[D_TABLE] = 1'b1;
        pt_mem[slot] = e;
        next_frame++;
        return int'(next_frame - 1);
    endfunction

    function automatic int leaf_frame(logic [ADDR_W-1:0] va);
        int f;
        int lvl;
        f = 0;
        for (lvl = 0; lvl < 3 && f >= 0; lvl++)
            f = table_frame(pt_mem[f * ENTRIES + int'(level_idx(va, lvl))]);
        return f;
    endfunction

    function automatic logic [ENTRY_W-1:0] page_desc(in_item_t r);
        logic [ENTRY_W-1:0] d;
        d = '0;
        d[47:12] = r.phys_in[47:12];
        d[D_VALID] = 1'b1;
        d[D_TABLE] = 1'b1;
        d[D_AF] = 1'b1;
        if (r.flag_device) begin
            d[D_ATTR_DEV] = 1'b1;
            d[D_UXN] = 1'b1;
            d[D_PXN] = 1'b1;
        end else begin
            d[D_SH_HI] = 1'b1;
            d[D_SH_LO] = 1'b1;
        end
        if (!r.flag_write) d[D_AP_RO] = 1'b1;
        if (r.flag_user) d[D_AP_USER] = 1'b1;
        if (!r.flag_exec) begin
            d[D_UXN] = 1'b1;
            d[D_PXN] = 1'b1;
        end else if (!r.flag_user) begin
            d[D_UXN] = 1'b1;
        end
        return d;
    endfunction

    // Applies one request to the shadow tables and returns its outcome.
    function automatic out_item_t apply_page_op(in_item_t r);
        out_item_t res;
        int f;
        int lvl;
        int slot;
        logic [ENTRY_W-1:0] leaf;
        res = '0;
        res.status = 1'b1;
        case (r.op)
            OP_MAP: begin
                if (r.virt_addr[11:0] == 12'h0 && r.phys_in[11:0] == 12'h0) begin
                    f = 0;
                    for (lvl = 0; lvl < 3 && f >= 0; lvl++)
                        f = descend_map(f, level_idx(r.virt_addr, lvl));
                    if (f >= 0) begin
                        slot = f * ENTRIES + int'(level_idx(r.virt_addr, 3));
                        if (!pt_mem[slot][D_VALID]) begin
                            pt_mem[slot] = page_desc(r);
                            res.status = 1'b0;
                        end
                    end
                end
            end
            OP_UNMAP: begin
                if (r.virt_addr[11:0] == 12'h0) begin
                    f = leaf_frame(r.virt_addr);
                    if (f >= 0) begin
                        slot = f * ENTRIES + int'(level_idx(r.virt_addr, 3));
                        if (pt_mem[slot][D_VALID]) begin
                            pt_mem[slot] = '0;
                            res.status = 1'b0;
                        end
                    end
                end
            end
            OP_XLATE: begin
                res.status = 1'b0;
                leaf = '0;
                f = leaf_frame(r.virt_addr);
                if (f >= 0) leaf = pt_mem[f * ENTRIES + int'(level_idx(r.virt_addr, 3))];
                res.leaf_word = leaf;
                if (leaf[D_VALID] && leaf[D_TABLE])
                    res.phys_out = {leaf[47:12], r.virt_addr[11:0]};
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Mostly zero or short, a few long, and now and then a stretch with no idling at all.
    function automatic int unsigned idle_len(inout int unsigned calm_left);
        int unsigned r;
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] va_of(logic [8:0] l0, logic [8:0] l1,
                                                 logic [8:0] l2, logic [8:0] l3,
                                                 logic [11:0] offs);
        return {l0, l1, l2, l3, offs};
    endfunction

    task automatic queue_req(logic [1:0] op, logic [ADDR_W-1:0] va,
                             logic [ADDR_W-1:0] pa, logic [3:0] flags);
        in_item_t r;
        r.op = op;
        r.virt_addr = va;
        r.phys_in = pa;
        {r.flag_write, r.flag_exec, r.flag_user, r.flag_device} = flags;
        page_reqs_q.push_back(r);
        n_queued++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_va(logic [1:0] op);
        logic [ADDR_W-1:0] va;
        if ($urandom_range(0, 99) < 85) begin
            va = {leaf_pool[$urandom_range(0, POOL_N - 1)], 21'h0};
            if ($urandom_range(0, 4) == 0) va[20:12] = 9'($urandom);
            else va[20:12] = 9'($urandom_range(0, 15));
        end else begin
            va = 48'({$urandom, $urandom});
        end
        if (op == OP_XLATE || $urandom_range(0, 19) == 0) va[11:0] = 12'($urandom);
        else va[11:0] = 12'h0;
        return va;
    endfunction

    task automatic add_random(int n);
        int k;
        int sel;
        logic [1:0] op;
        logic [ADDR_W-1:0] pa;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) op = OP_MAP;
            else if (sel < 62) op = OP_UNMAP;
            else if (sel < 96) op = OP_XLATE;
            else op = OP_RSVD;
            pa = 48'({$urandom, $urandom});
            if ($urandom_range(0, 19) != 0) pa[11:0] = 12'h0;
            queue_req(op, pick_va(op), pa, 4'($urandom));
        end
    endtask

    task automatic drain();
        while (n_done != n_queued) @(posedge aclk);
    endtask

    task automatic set_table_base(logic [ADDR_W-1:0] v);
        @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        tbl_base = {v[47:12], 12'h000};
        cfg_valid <= 1'b0;
    endtask

    task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (op_outcomes_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("%0t: result with nothing pending: %h", $realtime, got);
            return;
        end
        want = op_outcomes_q.pop_front();
        if (got.status !== want.status)
            flag_field("status", 64'(want.status), 64'(got.status));
        if (got.leaf_word !== want.leaf_word)
            flag_field("leaf_word", want.leaf_word, got.leaf_word);
        if (got.phys_out !== want.phys_out)
            flag_field("phys_out", 64'(want.phys_out), 64'(got.phys_out));
    endtask

    // Request driver: predicts each transaction as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready)
                op_outcomes_q.push_back(apply_page_op(s_data));
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (page_reqs_q.size() != 0) begin
                    s_data  <= page_reqs_q.pop_front();
                    s_valid <= 1'b1;
                    tx_gap  <= idle_len(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall <= 0;
        end else if (m_valid && m_ready) begin
            check_result(m_data);
            n_done <= n_done + 1;
            rx_wait = idle_len(rx_calm);
            m_ready  <= (rx_wait == 0);
            rx_stall <= (rx_wait == 0) ? 0 : rx_wait - 1;
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cyc < CYCLE_CAP) begin
            @(posedge aclk);
            cyc++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] base_a;
        for (int i = 0; i < N_FRAMES * ENTRIES; i++) pt_mem[i] = '0;
        leaf_pool[0] = {9'h1ff, 9'h1ff, 9'h1ff};
        leaf_pool[1] = {9'd0, 9'd0, 9'd0};
        leaf_pool[2] = {9'd0, 9'd0, 9'd1};
        leaf_pool[3] = {9'd0, 9'd1, 9'd0};
        leaf_pool[4] = {9'd1, 9'd0, 9'd0};
        leaf_pool[5] = {9'd1, 9'd5, 9'd3};
        leaf_pool[6] = {9'd2, 9'd0, 9'd0};
        base_a = 48'({$urandom, $urandom});
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Base at the very top, so frame addresses wrap past zero.
        set_table_base(48'hFFFF_FFFF_FFFF);
        queue_req(OP_MAP, TOP_PAGE, TOP_PAGE, 4'b1111);
        queue_req(OP_XLATE, 48'hFFFF_FFFF_FFFF, '0, 4'b0000);
        queue_req(OP_MAP, TOP_PAGE, '0, 4'b0000);
        queue_req(OP_UNMAP, TOP_PAGE, '0, 4'b0000);
        queue_req(OP_UNMAP, TOP_PAGE, '0, 4'b0000);
        queue_req(OP_MAP, TOP_PAGE, '0, 4'b0000);
        queue_req(OP_XLATE, TOP_PAGE | 48'h123, '0, 4'b0000);
        queue_req(OP_MAP, TOP_PAGE | 48'h1, '0, 4'b1010);
        queue_req(OP_MAP, TOP_PAGE - 48'h1000, 48'h800, 4'b0101);
        queue_req(OP_UNMAP, TOP_PAGE | 48'h800, '0, 4'b0000);
        queue_req(OP_RSVD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'b1111);
        queue_req(OP_XLATE, '0, '0, 4'b0000);
        drain();

        // New base: the old root entries become stale, then the frames run out.
        set_table_base(base_a);
        queue_req(OP_XLATE, TOP_PAGE, '0, 4'b0000);
        queue_req(OP_MAP, TOP_PAGE - 48'h1000, 48'h5000, 4'b1111);
        queue_req(OP_MAP, va_of(0, 0, 0, 0, 0), '0, 4'b1100);
        queue_req(OP_MAP, va_of(0, 0, 1, 2, 0), 48'h1234_5678_9000, 4'b0110);
        queue_req(OP_MAP, va_of(0, 1, 0, 3, 0), 48'hABCD_EF01_2000, 4'b0101);
        queue_req(OP_MAP, va_of(1, 0, 0, 4, 0), 48'h0000_0000_1000, 4'b1001);
        queue_req(OP_MAP, va_of(1, 5, 3, 5, 0), 48'h8000_0000_0000, 4'b1110);
        queue_req(OP_MAP, va_of(2, 0, 0, 6, 0), 48'h4000_0000_0000, 4'b1111);
        queue_req(OP_MAP, va_of(2, 0, 0, 7, 0), 48'h4000_0000_1000, 4'b1111);
        queue_req(OP_XLATE, va_of(0, 0, 0, 0, 12'habc), '0, 4'b0000);
        queue_req(OP_UNMAP, va_of(0, 0, 0, 0, 0), '0, 4'b0000);
        queue_req(OP_XLATE, va_of(0, 0, 0, 0, 0), '0, 4'b0000);
        queue_req(OP_UNMAP, va_of(1, 5, 3, 7, 0), '0, 4'b0000);
        add_random(500);
        drain();
        add_random(500);
        drain();

        set_table_base(48'h0);
        add_random(150);
        drain();

        // Back to the wrapped base: the tables built first are reachable again.
        set_table_base({36'hF_FFFF_FFFF, 12'($urandom)});
        add_random(300);
        drain();

        set_table_base({base_a[47:12], 12'($urandom)});
        add_random(375);
        drain();

        repeat (SETTLE) @(posedge aclk);
        if (err_cnt == 0 && op_outcomes_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
